// File: rtl/crc32fc_pkg.sv
// Package for the CRC-32 frame checker: constants, the result beat type and
// the reflected CRC-32 update functions. No dependencies.
`timescale 1ns / 1ps

package crc32fc_pkg;

  // Field and register widths.
  localparam int DATA_W   = 32;
  localparam int FW_W     = 19;
  localparam int IDX_W    = 18;
  localparam int CNT_W    = 32;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Frame length limits and the register reset value.
  localparam int MAX_FRAME_WORDS = 262144;
  localparam int MIN_FRAME_WORDS = 2;
  localparam logic [FW_W-1:0] FRAME_WORDS_RST = FW_W'(MAX_FRAME_WORDS);

  // Every SampleStep-th word is checked against its index.
  localparam int SAMPLE_STEP_LG = 6;
  localparam int SampleStep     = 1 << SAMPLE_STEP_LG;

  // Register indexes.
  localparam logic REG_FRAME_WORDS = 1'b0;

  // CRC constants.
  localparam logic [DATA_W-1:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [DATA_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

  // One result beat.
  typedef struct packed {
    logic              frame_ok;
    logic              crc_bad;
    logic              pattern_bad;
    logic [DATA_W-1:0] computed_crc;
    logic [CNT_W-1:0]  fail_count;
    logic [CNT_W-1:0]  frame_count;
  } result_t;

  // Reflected CRC-32 update over one byte, one bit per step.
  function automatic logic [DATA_W-1:0] crc_byte(input logic [DATA_W-1:0] crc,
                                                 input logic [7:0] data);
    logic [DATA_W-1:0] c;
    c = crc ^ {24'h0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Update over a full word, low byte first.
  function automatic logic [DATA_W-1:0] crc_word(input logic [DATA_W-1:0] crc,
                                                 input logic [DATA_W-1:0] w);
    logic [DATA_W-1:0] c;
    c = crc_byte(crc, w[7:0]);
    c = crc_byte(c, w[15:8]);
    c = crc_byte(c, w[23:16]);
    c = crc_byte(c, w[31:24]);
    return c;
  endfunction

endpackage

// File: rtl/crc32_frame_checker_unit.sv
// Flow: a check word's result goes from the input register into the result
// register; data words give no result. Throughput: one word per cycle while
// no check word waits on a stalled result, set by the four-byte CRC update.
// A stalled result holds back only a following check word and what follows it.
// Reset (rst_n, synchronous) empties both registers, clears the frame state
// and counters, and sets frame_words to 262144.
`timescale 1ns / 1ps

module crc32_frame_checker_unit
  import crc32fc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_frame_ok,
  output logic              out_crc_bad,
  output logic              out_pattern_bad,
  output logic [DATA_W-1:0] out_computed_crc,
  output logic [CNT_W-1:0]  out_fail_count,
  output logic [CNT_W-1:0]  out_frame_count
);

  logic [IDX_W-1:0] last_idx;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  result_t          out_res;

  // Configuration register.
  crc32fc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .last_idx (last_idx)
  );

  // Input register and frame checking.
  crc32fc_frame_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_word (in_data_word),
    .last_idx     (last_idx),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // Result register.
  crc32fc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_frame_ok     = out_res.frame_ok;
  assign out_crc_bad      = out_res.crc_bad;
  assign out_pattern_bad  = out_res.pattern_bad;
  assign out_computed_crc = out_res.computed_crc;
  assign out_fail_count   = out_res.fail_count;
  assign out_frame_count  = out_res.frame_count;

  // A pattern failure is only reported when the CRC matched.
  a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_crc_bad && out_pattern_bad))
    else $error("crc_bad and pattern_bad both set");

  // The frame passes exactly when neither check failed.
  a_ok_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_ok == !(out_crc_bad || out_pattern_bad)))
    else $error("frame_ok disagrees with the failure flags");

  // A result beat taken is never shown again with the same frame count.
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=>
      (!out_valid || (out_frame_count != $past(out_frame_count))))
    else $error("result beat repeated");

  // A stalled result never lets a new result be loaded over it.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !res_ready)
    else $error("result register overwritten while stalled");

endmodule

// File: rtl/crc32fc_cfg_regs.sv
// APB configuration register for the frame checker: holds frame_words and
// the clamped index of the check word. Depends on crc32fc_pkg.
`timescale 1ns / 1ps

module crc32fc_cfg_regs
  import crc32fc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [IDX_W-1:0]  last_idx
);

  logic [FW_W-1:0]  frame_words_r;
  logic [FW_W-1:0]  frame_words_nxt;
  logic [IDX_W-1:0] last_idx_r;
  logic [IDX_W-1:0] last_idx_nxt;
  logic             reg_idx;
  logic             wr_en;

  // Register index is the word address; low address bits are ignored.
  assign reg_idx = paddr[APB_AW-1];
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_FRAME_WORDS);
  assign pready  = 1'b1;

  // Read data.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_FRAME_WORDS: prdata = APB_DW'(frame_words_r);
      default:         prdata = '0;
    endcase
  end

  // Write path and clamp of the frame length to its legal range. The clamp
  // follows the value being written so both registers change together.
  always_comb begin
    frame_words_nxt = frame_words_r;
    if (wr_en) begin
      frame_words_nxt = pwdata[FW_W-1:0];
    end
    if (frame_words_nxt < FW_W'(MIN_FRAME_WORDS)) begin
      last_idx_nxt = IDX_W'(MIN_FRAME_WORDS - 1);
    end else if (frame_words_nxt > FW_W'(MAX_FRAME_WORDS)) begin
      last_idx_nxt = IDX_W'(MAX_FRAME_WORDS - 1);
    end else begin
      last_idx_nxt = IDX_W'(frame_words_nxt - FW_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_words_r <= FRAME_WORDS_RST;
      last_idx_r    <= IDX_W'(MAX_FRAME_WORDS - 1);
    end else begin
      frame_words_r <= frame_words_nxt;
      last_idx_r    <= last_idx_nxt;
    end
  end

  assign last_idx = last_idx_r;

endmodule

// File: rtl/crc32fc_frame_core.sv
// Input register and per-frame state of the frame checker: runs the CRC,
// the sampled index check and the frame counters. Depends on crc32fc_pkg.
`timescale 1ns / 1ps

module crc32fc_frame_core
  import crc32fc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data_word,
  input  logic [IDX_W-1:0]  last_idx,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [DATA_W-1:0] s1_word_r, s1_word_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [DATA_W-1:0] crc_r, crc_nxt;
  logic              mis_r, mis_nxt;
  logic [CNT_W-1:0]  fail_cnt_r, fail_cnt_nxt;
  logic [CNT_W-1:0]  frame_cnt_r, frame_cnt_nxt;

  logic              is_check;
  logic              advance;
  logic              sampled;
  logic [DATA_W-1:0] final_crc;
  logic              crc_bad;
  logic              pattern_bad;
  logic              fail;

  // The held beat is the check word once the index reaches the last slot.
  assign is_check  = idx_r >= last_idx;
  assign advance   = s1_valid_r && (!is_check || res_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign res_valid = s1_valid_r && is_check;

  // Check word evaluation.
  assign final_crc   = crc_r ^ CRC_ALL_ONES;
  assign crc_bad     = s1_word_r != final_crc;
  assign pattern_bad = !crc_bad && mis_r;
  assign fail        = crc_bad || pattern_bad;
  assign sampled     = (idx_r[SAMPLE_STEP_LG-1:0] == '0) &&
                       (s1_word_r != DATA_W'(idx_r));

  // Counter values that include this frame.
  assign fail_cnt_nxt  = advance && is_check ? fail_cnt_r + CNT_W'(fail) : fail_cnt_r;
  assign frame_cnt_nxt = advance && is_check ? frame_cnt_r + CNT_W'(1) : frame_cnt_r;

  always_comb begin
    res.frame_ok     = !fail;
    res.crc_bad      = crc_bad;
    res.pattern_bad  = pattern_bad;
    res.computed_crc = final_crc;
    res.fail_count   = fail_cnt_r + CNT_W'(fail);
    res.frame_count  = frame_cnt_r + CNT_W'(1);
  end

  // Input register.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_word_nxt  = s1_word_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
      s1_word_nxt  = in_data_word;
    end
  end

  // Frame state update.
  always_comb begin
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    mis_nxt = mis_r;
    if (advance) begin
      if (is_check) begin
        idx_nxt = '0;
        crc_nxt = CRC_ALL_ONES;
        mis_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
        crc_nxt = crc_word(crc_r, s1_word_r);
        mis_nxt = mis_r || sampled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      idx_r       <= '0;
      crc_r       <= CRC_ALL_ONES;
      mis_r       <= 1'b0;
      fail_cnt_r  <= '0;
      frame_cnt_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      mis_r       <= mis_nxt;
      fail_cnt_r  <= fail_cnt_nxt;
      frame_cnt_r <= frame_cnt_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    s1_word_r <= s1_word_nxt;
  end

endmodule

// File: rtl/crc32fc_out_reg.sv
// Result register of the frame checker: holds one result beat until the
// consumer takes it. Depends on crc32fc_pkg.
`timescale 1ns / 1ps

module crc32fc_out_reg
  import crc32fc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  output logic    res_ready,
  input  result_t res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;
  logic    load;

  // Load a new beat when the register is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
    if (load) begin
      out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
